// ===== design/fpm_pkg.sv =====
// ----------------------------------------------------------------------------
// fpm_pkg
// Shared codes for the FIFO port matcher: request types, actions, status
// codes, per-port states and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package fpm_pkg;

  localparam logic [1:0] REQ_OUT      = 2'd0;
  localparam logic [1:0] REQ_IN       = 2'd1;
  localparam logic [1:0] REQ_EVAL     = 2'd2;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  localparam logic [1:0] ACT_TRANSFER   = 2'd0;
  localparam logic [1:0] ACT_NEEDED     = 2'd1;
  localparam logic [1:0] ACT_NOT_NEEDED = 2'd2;
  localparam logic [1:0] ACT_STATUS     = 2'd3;

  localparam logic [1:0] ST_NEED_DATA = 2'd0;
  localparam logic [1:0] ST_PORT_FULL = 2'd1;
  localparam logic [1:0] ST_FINISHED  = 2'd2;

  localparam logic [1:0] IN_NOT_NEEDED = 2'd0;
  localparam logic [1:0] IN_NEEDED     = 2'd1;
  localparam logic [1:0] IN_HAS_DATA   = 2'd2;
  localparam logic [1:0] IN_FINISHED   = 2'd3;

  localparam logic [1:0] OUT_NOT_ACTIVE = 2'd0;
  localparam logic [1:0] OUT_NEED_DATA  = 2'd1;
  localparam logic [1:0] OUT_FINISHED   = 2'd2;

  localparam logic CFG_INPUT_COUNT  = 1'b0;
  localparam logic CFG_OUTPUT_COUNT = 1'b1;

  localparam logic [4:0] CNT_SAT = 5'd31;

endpackage

`default_nettype wire

// ===== design/fifo_port_matcher_top.sv =====
// ----------------------------------------------------------------------------
// fifo_port_matcher_top
// Pairs waiting consumer ports with producer ports holding data, FIFO order.
// ----------------------------------------------------------------------------
// One request at a time. The first request after reset runs an init sweep over
// all MAX_PORTS entries of the port state memories. Update requests pass through
// dispatch, memory read and write back. Evaluate does a read-modify-write of the
// input state memory for each transfer, then the need grants, with dispatch,
// queue exits and a closing status around them; one result leaves per cycle
// at most, and a stalled output holds the sequencer.
`default_nettype none

module fifo_port_matcher_top #(
  parameter int MAX_PORTS = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic [4:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] req_type_i,
  input  wire logic [3:0] port_index_i,
  input  wire logic       port_done_i,
  input  wire logic       port_ready_i,
  input  wire logic       chunk_is_final_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      action_o,
  output logic [3:0]      src_port_o,
  output logic [3:0]      dst_port_o,
  output logic [1:0]      status_code_o,
  output logic            close_all_inputs_o,
  output logic            finish_all_outputs_o,
  output logic            last_o
);

  localparam int AW = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
  localparam int CW = $clog2(MAX_PORTS + 1);
  localparam int EW = 7;
  localparam logic [EW-1:0] MaxP = EW'(MAX_PORTS);
  localparam logic [AW-1:0] LastIdx = AW'(MAX_PORTS - 1);
  localparam logic [CW-1:0] FullCnt = CW'(MAX_PORTS);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_DISP, S_OUPD, S_IUPD, S_EPAIR, S_EPIN, S_EEND, S_EGRANT, S_ESTAT
  } state_e;

  state_e state_q, state_d;
  logic init_q, init_d;
  logic [1:0] req_q;
  logic [3:0] p_q;
  logic done_q, rdy_q, fin_q;
  logic [4:0] in_cnt_q, out_cnt_q;
  logic [4:0] done_in_q, done_in_d, done_out_q, done_out_d;
  logic [4:0] n_q, n_d;
  logic [CW-1:0] want_q, want_d, sweep_q, sweep_d;
  logic [3:0] i_q, i_d;

  logic [3:0] wo_mem [MAX_PORTS];
  logic [3:0] di_mem [MAX_PORTS];
  logic [3:0] id_mem [MAX_PORTS];
  logic [AW-1:0] wo_head_q, wo_tail_q, di_head_q, di_tail_q, id_head_q, id_tail_q;
  logic [CW-1:0] wo_cnt_q, di_cnt_q, id_cnt_q;
  logic wo_push, wo_pop, di_push, di_pop, id_push, id_pop;
  logic [3:0] wo_wdata, di_wdata, id_wdata;

  logic [1:0] st_mem  [MAX_PORTS];
  logic       fl_mem  [MAX_PORTS];
  logic [1:0] om_mem  [MAX_PORTS];
  logic [1:0] st_rd_q, om_rd_q;
  logic       fl_rd_q;
  logic [AW-1:0] rd_a;
  logic st_we, fl_we, om_we;
  logic [AW-1:0] st_wa, fl_wa, om_wa;
  logic [1:0] st_wd, om_wd;
  logic fl_wd;

  logic ov_q, last_q, cl_q, fa_q;
  logic [1:0] act_q, stc_q;
  logic [3:0] src_q, dst_q;
  logic emit, e_last, e_cl, e_fa;
  logic [1:0] e_act, e_st;
  logic [3:0] e_src, e_dst;

  logic [EW-1:0] eff_in, eff_out, p_ext;
  logic out_free, all_out_done, all_in_done;

  function automatic logic [AW-1:0] nxt(input logic [AW-1:0] h);
    nxt = (h == LastIdx) ? '0 : h + 1'b1;
  endfunction

  assign eff_in  = ({2'b0, in_cnt_q} > MaxP) ? MaxP : {2'b0, in_cnt_q};
  assign eff_out = ({2'b0, out_cnt_q} > MaxP) ? MaxP : {2'b0, out_cnt_q};
  assign p_ext = {3'b0, p_q};
  assign all_out_done = {2'b0, done_out_q} >= eff_out;
  assign all_in_done  = {2'b0, done_in_q} >= eff_in;
  assign out_free = !ov_q || !out_stall_i;
  assign rd_a = (state_q == S_EPAIR) ? AW'(di_mem[di_head_q]) : AW'(p_q);

  always_comb begin
    state_d = state_q;
    init_d = init_q;
    done_in_d = done_in_q;
    done_out_d = done_out_q;
    n_d = n_q;
    want_d = want_q;
    sweep_d = sweep_q;
    i_d = i_q;
    wo_push = 1'b0; wo_pop = 1'b0; wo_wdata = p_q;
    di_push = 1'b0; di_pop = 1'b0; di_wdata = p_q;
    id_push = 1'b0; id_pop = 1'b0; id_wdata = p_q;
    st_we = 1'b0; st_wa = AW'(p_q); st_wd = fpm_pkg::IN_NOT_NEEDED;
    fl_we = 1'b0; fl_wa = AW'(p_q); fl_wd = 1'b0;
    om_we = 1'b0; om_wa = AW'(p_q); om_wd = fpm_pkg::OUT_NOT_ACTIVE;
    emit = 1'b0; e_act = fpm_pkg::ACT_STATUS; e_src = '0; e_dst = '0;
    e_st = fpm_pkg::ST_NEED_DATA; e_cl = 1'b0; e_fa = 1'b0; e_last = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = init_q ? S_DISP : S_INIT;
          sweep_d = '0;
          n_d = '0;
        end
      end
      S_INIT: begin
        st_we = 1'b1; st_wa = sweep_q[AW-1:0];
        fl_we = 1'b1; fl_wa = sweep_q[AW-1:0];
        om_we = 1'b1; om_wa = sweep_q[AW-1:0];
        if (EW'(sweep_q) < eff_in) begin
          id_push = 1'b1;
          id_wdata = 4'(sweep_q);
        end
        sweep_d = sweep_q + 1'b1;
        if (sweep_q[AW-1:0] == LastIdx) begin
          init_d = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        unique case (req_q)
          fpm_pkg::REQ_OUT: state_d = (p_ext >= eff_out) ? S_IDLE : S_OUPD;
          fpm_pkg::REQ_IN: state_d = (all_out_done || p_ext >= eff_in) ? S_IDLE : S_IUPD;
          fpm_pkg::REQ_EVAL: begin
            if (!all_out_done) begin
              state_d = S_EPAIR;
            end else if (out_free) begin
              emit = 1'b1; e_st = fpm_pkg::ST_FINISHED; e_cl = 1'b1; e_last = 1'b1;
              state_d = S_IDLE;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_OUPD: begin
        if (done_q) begin
          if (om_rd_q != fpm_pkg::OUT_FINISHED) begin
            om_we = 1'b1; om_wd = fpm_pkg::OUT_FINISHED;
            if (done_out_q < fpm_pkg::CNT_SAT) done_out_d = done_out_q + 1'b1;
          end
        end else if (rdy_q && om_rd_q != fpm_pkg::OUT_NEED_DATA) begin
          om_we = 1'b1; om_wd = fpm_pkg::OUT_NEED_DATA;
          wo_push = 1'b1;
        end
        state_d = S_IDLE;
      end
      S_IUPD: begin
        if (done_q) begin
          if (st_rd_q != fpm_pkg::IN_FINISHED) begin
            st_we = 1'b1; st_wd = fpm_pkg::IN_FINISHED;
            if (done_in_q < fpm_pkg::CNT_SAT) done_in_d = done_in_q + 1'b1;
          end
          state_d = S_IDLE;
        end else if (rdy_q) begin
          fl_we = 1'b1; fl_wd = fin_q;
          if (st_rd_q != fpm_pkg::IN_HAS_DATA) begin
            st_we = 1'b1; st_wd = fpm_pkg::IN_HAS_DATA;
            di_push = 1'b1;
          end
          state_d = S_IDLE;
        end else if (out_free) begin
          emit = 1'b1; e_act = fpm_pkg::ACT_NOT_NEEDED; e_src = p_q; e_last = 1'b1;
          if (st_rd_q != fpm_pkg::IN_NOT_NEEDED) begin
            st_we = 1'b1; st_wd = fpm_pkg::IN_NOT_NEEDED;
            id_push = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      S_EPAIR: begin
        if (wo_cnt_q != '0 && di_cnt_q != '0 && n_q < 5'd16) begin
          if (out_free) begin
            emit = 1'b1; e_act = fpm_pkg::ACT_TRANSFER;
            e_src = di_mem[di_head_q]; e_dst = wo_mem[wo_head_q];
            wo_pop = 1'b1; di_pop = 1'b1;
            om_we = 1'b1; om_wa = AW'(wo_mem[wo_head_q]);
            i_d = di_mem[di_head_q];
            n_d = n_q + 1'b1;
            state_d = S_EPIN;
          end
        end else begin
          state_d = S_EEND;
        end
      end
      S_EPIN: begin
        st_wa = AW'(i_q);
        if (fl_rd_q && st_rd_q != fpm_pkg::IN_FINISHED) begin
          st_we = 1'b1; st_wd = fpm_pkg::IN_FINISHED;
          if (done_in_q < fpm_pkg::CNT_SAT) done_in_d = done_in_q + 1'b1;
        end else if (st_rd_q != fpm_pkg::IN_FINISHED) begin
          st_we = 1'b1; st_wd = fpm_pkg::IN_NOT_NEEDED;
        end
        state_d = S_EPAIR;
      end
      S_EEND: begin
        if (!all_in_done) begin
          want_d = wo_cnt_q;
          state_d = S_EGRANT;
        end else if (out_free) begin
          emit = 1'b1; e_st = fpm_pkg::ST_FINISHED; e_fa = 1'b1; e_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_EGRANT: begin
        if (id_cnt_q != '0 && want_q != '0 && n_q < 5'd16) begin
          if (out_free) begin
            emit = 1'b1; e_act = fpm_pkg::ACT_NEEDED; e_src = id_mem[id_head_q];
            id_pop = 1'b1;
            st_we = 1'b1; st_wa = AW'(id_mem[id_head_q]); st_wd = fpm_pkg::IN_NEEDED;
            want_d = want_q - 1'b1;
            n_d = n_q + 1'b1;
          end
        end else begin
          state_d = S_ESTAT;
        end
      end
      S_ESTAT: begin
        if (out_free) begin
          emit = 1'b1; e_last = 1'b1;
          e_st = (wo_cnt_q != '0) ? fpm_pkg::ST_NEED_DATA : fpm_pkg::ST_PORT_FULL;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      init_q <= 1'b0;
      in_cnt_q <= 5'd1;
      out_cnt_q <= 5'd1;
      done_in_q <= '0;
      done_out_q <= '0;
      n_q <= '0;
      want_q <= '0;
      sweep_q <= '0;
      wo_head_q <= '0; wo_tail_q <= '0; wo_cnt_q <= '0;
      di_head_q <= '0; di_tail_q <= '0; di_cnt_q <= '0;
      id_head_q <= '0; id_tail_q <= '0; id_cnt_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q <= init_d;
      done_in_q <= done_in_d;
      done_out_q <= done_out_d;
      n_q <= n_d;
      want_q <= want_d;
      sweep_q <= sweep_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == fpm_pkg::CFG_INPUT_COUNT) in_cnt_q <= cfg_data_i;
        if (cfg_idx_i == fpm_pkg::CFG_OUTPUT_COUNT) out_cnt_q <= cfg_data_i;
      end
      if (wo_push && wo_cnt_q != FullCnt) begin
        wo_tail_q <= nxt(wo_tail_q); wo_cnt_q <= wo_cnt_q + 1'b1;
      end else if (wo_pop) begin
        wo_head_q <= nxt(wo_head_q); wo_cnt_q <= wo_cnt_q - 1'b1;
      end
      if (di_push && di_cnt_q != FullCnt) begin
        di_tail_q <= nxt(di_tail_q); di_cnt_q <= di_cnt_q + 1'b1;
      end else if (di_pop) begin
        di_head_q <= nxt(di_head_q); di_cnt_q <= di_cnt_q - 1'b1;
      end
      if (id_push && id_cnt_q != FullCnt) begin
        id_tail_q <= nxt(id_tail_q); id_cnt_q <= id_cnt_q + 1'b1;
      end else if (id_pop) begin
        id_head_q <= nxt(id_head_q); id_cnt_q <= id_cnt_q - 1'b1;
      end
      if (emit) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      req_q <= req_type_i;
      p_q <= port_index_i;
      done_q <= port_done_i;
      rdy_q <= port_ready_i;
      fin_q <= chunk_is_final_i;
    end
    i_q <= i_d;
    if (emit) begin
      act_q <= e_act; src_q <= e_src; dst_q <= e_dst; stc_q <= e_st;
      cl_q <= e_cl; fa_q <= e_fa; last_q <= e_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wo_push && wo_cnt_q != FullCnt) wo_mem[wo_tail_q] <= wo_wdata;
    if (di_push && di_cnt_q != FullCnt) di_mem[di_tail_q] <= di_wdata;
    if (id_push && id_cnt_q != FullCnt) id_mem[id_tail_q] <= id_wdata;
    if (st_we) st_mem[st_wa] <= st_wd;
    if (fl_we) fl_mem[fl_wa] <= fl_wd;
    if (om_we) om_mem[om_wa] <= om_wd;
    st_rd_q <= st_mem[rd_a];
    fl_rd_q <= fl_mem[rd_a];
    om_rd_q <= om_mem[rd_a];
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign action_o = act_q;
  assign src_port_o = src_q;
  assign dst_port_o = dst_q;
  assign status_code_o = stc_q;
  assign close_all_inputs_o = cl_q;
  assign finish_all_outputs_o = fa_q;
  assign last_o = last_q;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks fifo_port_matcher_top against a predictor of its own. Port updates
// and evaluate requests go in through the request channel. Each result that
// leaves is compared field by field, in order, with the expected results.
// The run uses several port-count settings, the extremes among them, and
// idles both channels at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int NPORT = 16;
  localparam int WATCH_LIMIT = 20000;
  localparam int SETTLE = 60;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] src;
    logic [3:0] dst;
    logic [1:0] status;
    logic       close_in;
    logic       finish_out;
    logic       last;
  } result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_idx_i = 1'b0;
  logic [4:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] req_type_i = '0;
  logic [3:0] port_index_i = '0;
  logic       port_done_i = 1'b0;
  logic       port_ready_i = 1'b0;
  logic       chunk_is_final_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] action_o;
  logic [3:0] src_port_o;
  logic [3:0] dst_port_o;
  logic [1:0] status_code_o;
  logic       close_all_inputs_o;
  logic       finish_all_outputs_o;
  logic       last_o;

  fifo_port_matcher_top dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [4:0] in_count = 5'd1;
  logic [4:0] out_count = 5'd1;
  logic       ports_up = 1'b0;
  logic [1:0] in_state [NPORT];
  logic       in_final [NPORT];
  logic [1:0] out_state [NPORT];
  logic [3:0] waiting_outs [$];
  logic [3:0] data_ins [$];
  logic [3:0] idle_ins [$];
  int         done_ins = 0;
  int         done_outs = 0;

  result_t    expected_results [$];
  int         errors = 0;
  int         reqs_sent = 0;
  int         results_seen = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  function automatic int eff_count(logic [4:0] c);
    return (c > NPORT) ? NPORT : int'(c);
  endfunction

  function automatic void push_port(ref logic [3:0] q [$], input logic [3:0] p);
    if (q.size() < NPORT) q.push_back(p);
  endfunction

  function automatic result_t mk(logic [1:0] a, logic [3:0] s, logic [3:0] d,
                                 logic [1:0] st, logic c, logic f);
    result_t r;
    r.action = a; r.src = s; r.dst = d; r.status = st;
    r.close_in = c; r.finish_out = f; r.last = 1'b0;
    return r;
  endfunction

  function automatic void predict_matcher(logic [1:0] rt, logic [3:0] p, logic d,
                                          logic rdy, logic f);
    result_t    res [$];
    logic [3:0] o, i;
    int         want;
    if (!ports_up) begin
      ports_up = 1'b1;
      for (int k = 0; k < NPORT; k++) begin
        in_state[k] = fpm_pkg::IN_NOT_NEEDED;
        in_final[k] = 1'b0;
        out_state[k] = fpm_pkg::OUT_NOT_ACTIVE;
      end
      for (int k = 0; k < eff_count(in_count); k++) push_port(idle_ins, 4'(k));
    end
    if (rt == fpm_pkg::REQ_OUT) begin
      if (p >= eff_count(out_count)) return;
      if (d) begin
        if (out_state[p] != fpm_pkg::OUT_FINISHED) begin
          out_state[p] = fpm_pkg::OUT_FINISHED;
          if (done_outs < 31) done_outs++;
        end
      end else if (rdy && out_state[p] != fpm_pkg::OUT_NEED_DATA) begin
        out_state[p] = fpm_pkg::OUT_NEED_DATA;
        push_port(waiting_outs, p);
      end
      return;
    end
    if (rt == fpm_pkg::REQ_IN) begin
      if (done_outs >= eff_count(out_count) || p >= eff_count(in_count)) return;
      if (d) begin
        if (in_state[p] != fpm_pkg::IN_FINISHED) begin
          in_state[p] = fpm_pkg::IN_FINISHED;
          if (done_ins < 31) done_ins++;
        end
      end else if (rdy) begin
        in_final[p] = f;
        if (in_state[p] != fpm_pkg::IN_HAS_DATA) begin
          in_state[p] = fpm_pkg::IN_HAS_DATA;
          push_port(data_ins, p);
        end
      end else begin
        res.push_back(mk(fpm_pkg::ACT_NOT_NEEDED, p, 4'd0, 2'd0, 1'b0, 1'b0));
        if (in_state[p] != fpm_pkg::IN_NOT_NEEDED) begin
          in_state[p] = fpm_pkg::IN_NOT_NEEDED;
          push_port(idle_ins, p);
        end
      end
    end else if (rt == fpm_pkg::REQ_EVAL) begin
      if (done_outs >= eff_count(out_count)) begin
        res.push_back(mk(fpm_pkg::ACT_STATUS, 4'd0, 4'd0, fpm_pkg::ST_FINISHED,
                         1'b1, 1'b0));
      end else begin
        while (waiting_outs.size() > 0 && data_ins.size() > 0 && res.size() < 16) begin
          o = waiting_outs.pop_front();
          i = data_ins.pop_front();
          res.push_back(mk(fpm_pkg::ACT_TRANSFER, i, o, 2'd0, 1'b0, 1'b0));
          out_state[o] = fpm_pkg::OUT_NOT_ACTIVE;
          if (in_final[i] && in_state[i] != fpm_pkg::IN_FINISHED) begin
            in_state[i] = fpm_pkg::IN_FINISHED;
            if (done_ins < 31) done_ins++;
          end else if (in_state[i] != fpm_pkg::IN_FINISHED) begin
            in_state[i] = fpm_pkg::IN_NOT_NEEDED;
          end
        end
        if (done_ins >= eff_count(in_count)) begin
          res.push_back(mk(fpm_pkg::ACT_STATUS, 4'd0, 4'd0, fpm_pkg::ST_FINISHED,
                           1'b0, 1'b1));
        end else begin
          want = waiting_outs.size();
          while (idle_ins.size() > 0 && want > 0 && res.size() < 16) begin
            i = idle_ins.pop_front();
            in_state[i] = fpm_pkg::IN_NEEDED;
            res.push_back(mk(fpm_pkg::ACT_NEEDED, i, 4'd0, 2'd0, 1'b0, 1'b0));
            want--;
          end
          res.push_back(mk(fpm_pkg::ACT_STATUS, 4'd0, 4'd0,
                           waiting_outs.size() > 0 ? fpm_pkg::ST_NEED_DATA
                                                   : fpm_pkg::ST_PORT_FULL,
                           1'b0, 1'b0));
        end
      end
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[k]) expected_results.push_back(res[k]);
  endfunction

  task automatic send_req(logic [1:0] rt, logic [3:0] p, logic d, logic rdy, logic f);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    req_type_i = rt; port_index_i = p; port_done_i = d;
    port_ready_i = rdy; chunk_is_final_i = f;
    do @(posedge clk_i); while (in_stall_o);
    predict_matcher(rt, p, d, rdy, f);
    reqs_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [4:0] val);
    cfg_we_i = 1'b1; cfg_idx_i = idx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == fpm_pkg::CFG_INPUT_COUNT) in_count = val;
    else out_count = val;
  endtask

  task automatic send_random(int n);
    int kind, lim;
    logic [1:0] rt;
    logic [3:0] p;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(99);
      rt = (kind < 35) ? fpm_pkg::REQ_OUT : (kind < 70) ? fpm_pkg::REQ_IN :
           (kind < 96) ? fpm_pkg::REQ_EVAL : fpm_pkg::REQ_RESERVED;
      lim = eff_count(rt == fpm_pkg::REQ_OUT ? out_count : in_count);
      if (lim == 0 || $urandom_range(9) == 0) p = 4'($urandom_range(15));
      else p = 4'($urandom_range(lim - 1));
      send_req(rt, p, $urandom_range(99) < 2, $urandom_range(99) < 70,
               $urandom_range(99) < 25);
    end
  endtask

  task automatic test_directed();
    write_cfg(fpm_pkg::CFG_INPUT_COUNT, 5'd16);
    write_cfg(fpm_pkg::CFG_OUTPUT_COUNT, 5'd16);
    send_req(fpm_pkg::REQ_OUT, 4'd0, 1'b0, 1'b1, 1'b0);
    send_req(fpm_pkg::REQ_OUT, 4'd15, 1'b0, 1'b1, 1'b0);
    send_req(fpm_pkg::REQ_OUT, 4'd15, 1'b0, 1'b1, 1'b0);
    send_req(fpm_pkg::REQ_IN, 4'd3, 1'b0, 1'b1, 1'b0);
    send_req(fpm_pkg::REQ_IN, 4'd15, 1'b0, 1'b1, 1'b1);
    send_req(fpm_pkg::REQ_EVAL, 4'd0, 1'b0, 1'b0, 1'b0);
    send_req(fpm_pkg::REQ_IN, 4'd5, 1'b0, 1'b0, 1'b0);
    send_req(fpm_pkg::REQ_OUT, 4'd7, 1'b0, 1'b1, 1'b0);
    send_req(fpm_pkg::REQ_EVAL, 4'd0, 1'b0, 1'b0, 1'b0);
    send_req(fpm_pkg::REQ_IN, 4'd0, 1'b0, 1'b1, 1'b0);
    send_req(fpm_pkg::REQ_IN, 4'd0, 1'b0, 1'b1, 1'b1);
    send_req(fpm_pkg::REQ_EVAL, 4'd0, 1'b0, 1'b0, 1'b0);
    send_req(fpm_pkg::REQ_IN, 4'd15, 1'b0, 1'b0, 1'b0);
    send_req(fpm_pkg::REQ_OUT, 4'd9, 1'b1, 1'b0, 1'b0);
    send_req(fpm_pkg::REQ_OUT, 4'd9, 1'b1, 1'b1, 1'b0);
    send_req(fpm_pkg::REQ_IN, 4'd4, 1'b1, 1'b0, 1'b0);
    send_req(fpm_pkg::REQ_IN, 4'd4, 1'b1, 1'b1, 1'b1);
    send_req(fpm_pkg::REQ_RESERVED, 4'd10, 1'b1, 1'b1, 1'b1);
    for (int k = 0; k < 4; k++) send_req(fpm_pkg::REQ_OUT, 4'(k + 10), 1'b0, 1'b1, 1'b0);
    send_req(fpm_pkg::REQ_EVAL, 4'd15, 1'b1, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_phase(logic [4:0] ni, logic [4:0] no, int idle_pct, int stall_pct,
                            int n);
    write_cfg(fpm_pkg::CFG_INPUT_COUNT, ni);
    write_cfg(fpm_pkg::CFG_OUTPUT_COUNT, no);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    send_random(n);
    drain();
  endtask

  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk_i) begin
    result_t got, exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {action_o, src_port_o, dst_port_o, status_code_o, close_all_inputs_o,
             finish_all_outputs_o, last_o};
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
          errors++;
        end
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_phase(5'd4, 5'd3, 20, 81, 130);
    test_phase(5'd31, 5'd31, 81, 20, 130);
    test_phase(5'd0, 5'd16, 0, 0, 12);
    test_phase(5'd9, 5'd0, 0, 0, 12);
    test_phase(5'd16, 5'd20, 0, 0, 105);
    $display("covered %0d requests and %0d results over six port-count settings",
             reqs_sent, results_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
